// ===== hdl/rv32alu_pkg.sv =====
package rv32alu_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = $clog2(REG_COUNT);

   localparam logic [6:0] OPC_OP      = 7'b0110011;
   localparam logic [6:0] OPC_OP_IMM  = 7'b0010011;
   localparam logic [6:0] FUNCT7_BASE = 7'b0000000;
   localparam logic [6:0] FUNCT7_ALT  = 7'b0100000;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   typedef struct packed {
      logic        en;
      logic [4:0]  idx;
      logic [31:0] data;
   } rf_write_type;

endpackage

// ===== hdl/rv32alu_regfile.sv =====
module rv32alu_regfile (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [4:0]                rs1_idx,
   input  logic [4:0]                rs2_idx,
   input  rv32alu_pkg::rf_write_type wr,
   output logic [31:0]               rs1_data,
   output logic [31:0]               rs2_data
);

   logic [31:0] mem [rv32alu_pkg::REG_COUNT];
   logic [rv32alu_pkg::REG_COUNT-1:0] valid_ff, valid_in;
   logic [31:0] rs1_raw_ff, rs2_raw_ff;
   logic        rs1_hit_ff, rs1_hit_in;
   logic        rs2_hit_ff, rs2_hit_in;
   logic        wr_in_range, rs1_in_range, rs2_in_range;

   assign wr_in_range  = {1'b0, wr.idx}  < 6'(rv32alu_pkg::REG_COUNT);
   assign rs1_in_range = {1'b0, rs1_idx} < 6'(rv32alu_pkg::REG_COUNT);
   assign rs2_in_range = {1'b0, rs2_idx} < 6'(rv32alu_pkg::REG_COUNT);

   // An entry that was never written since reset reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en && wr_in_range) begin
         valid_in[wr.idx[rv32alu_pkg::REG_IDX_W-1:0]] = 1'b1;
      end
      rs1_hit_in = rs1_in_range & valid_ff[rs1_idx[rv32alu_pkg::REG_IDX_W-1:0]];
      rs2_hit_in = rs2_in_range & valid_ff[rs2_idx[rv32alu_pkg::REG_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rs1_hit_ff <= 1'b0;
         rs2_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rs1_hit_ff <= rs1_hit_in;
            rs2_hit_ff <= rs2_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr.idx[rv32alu_pkg::REG_IDX_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rs1_raw_ff <= mem[rs1_idx[rv32alu_pkg::REG_IDX_W-1:0]];
         rs2_raw_ff <= mem[rs2_idx[rv32alu_pkg::REG_IDX_W-1:0]];
      end
   end

   assign rs1_data = rs1_hit_ff ? rs1_raw_ff : 32'd0;
   assign rs2_data = rs2_hit_ff ? rs2_raw_ff : 32'd0;

endmodule

// ===== hdl/rv32i_integer_alu_execute.sv =====
// A result passes the execute stage register and then the output register before it is offered.
// A result that waits on the output holds the execute stage and then the input.
// Throughput: one instruction per cycle while the output is not stalled; the
// register file is read in the transfer cycle and written back as the instruction
// leaves the execute stage, with forwarding between them. Reset clears the valid
// bit of every register (all read zero) and sets the program counter to zero.
module rv32i_integer_alu_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_write_value,
   output logic        rsp_write_done,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   logic        req_accept, s1_advance;
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_instr_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  out_dest_ff;
   logic [31:0] out_value_ff;
   logic        out_done_ff;
   logic [31:0] out_pc_ff;
   logic        out_status_ff;
   logic [31:0] pc_ff, pc_in, pc_plus4;
   rv32alu_pkg::rf_write_type wr, fwd_ff;

   logic [31:0] rs1_data, rs2_data, op_a, op_b, imm, result;
   logic [6:0]  opcode, funct7;
   logic [2:0]  funct3;
   logic [4:0]  rd, rs1, rs2, shamt;
   logic        ok, alt, wr_done;

   assign req_accept = req_valid & req_ready;
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign csr_ready  = 1'b1;

   rv32alu_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rs1_idx  (req_instr_word[19:15]),
      .rs2_idx  (req_instr_word[24:20]),
      .wr       (wr),
      .rs1_data (rs1_data),
      .rs2_data (rs2_data)
   );

   assign opcode = s1_instr_ff[6:0];
   assign rd     = s1_instr_ff[11:7];
   assign funct3 = s1_instr_ff[14:12];
   assign rs1    = s1_instr_ff[19:15];
   assign rs2    = s1_instr_ff[24:20];
   assign funct7 = s1_instr_ff[31:25];
   assign imm    = {{20{s1_instr_ff[31]}}, s1_instr_ff[31:20]};

   // The write that lands in the same cycle as the read is not yet in the
   // read data, so it is taken from the forwarding register.
   always_comb begin
      op_a = (fwd_ff.en && fwd_ff.idx == rs1) ? fwd_ff.data : rs1_data;
      ok   = 1'b1;
      alt  = 1'b0;
      if (opcode == rv32alu_pkg::OPC_OP) begin
         op_b = (fwd_ff.en && fwd_ff.idx == rs2) ? fwd_ff.data : rs2_data;
         if (funct7 == rv32alu_pkg::FUNCT7_ALT) begin
            alt = 1'b1;
            if (funct3 != rv32alu_pkg::F3_ADD && funct3 != rv32alu_pkg::F3_SR) begin
               ok = 1'b0;
            end
         end else if (funct7 != rv32alu_pkg::FUNCT7_BASE) begin
            ok = 1'b0;
         end
      end else if (opcode == rv32alu_pkg::OPC_OP_IMM) begin
         op_b = imm;
         if (funct3 == rv32alu_pkg::F3_SLL) begin
            if (funct7 != rv32alu_pkg::FUNCT7_BASE) begin
               ok = 1'b0;
            end
         end else if (funct3 == rv32alu_pkg::F3_SR) begin
            if (funct7 == rv32alu_pkg::FUNCT7_ALT) begin
               alt = 1'b1;
            end else if (funct7 != rv32alu_pkg::FUNCT7_BASE) begin
               ok = 1'b0;
            end
         end
      end else begin
         op_b = 32'd0;
         ok   = 1'b0;
      end
   end

   assign shamt = op_b[4:0];

   always_comb begin
      unique case (funct3)
         rv32alu_pkg::F3_ADD: begin
            result = (alt && opcode == rv32alu_pkg::OPC_OP) ? op_a - op_b : op_a + op_b;
         end
         rv32alu_pkg::F3_SLL:  result = op_a << shamt;
         rv32alu_pkg::F3_SLT:  result = {31'd0, $signed(op_a) < $signed(op_b)};
         rv32alu_pkg::F3_SLTU: result = {31'd0, op_a < op_b};
         rv32alu_pkg::F3_XOR:  result = op_a ^ op_b;
         rv32alu_pkg::F3_SR: begin
            result = alt ? 32'($signed(op_a) >>> shamt) : op_a >> shamt;
         end
         rv32alu_pkg::F3_OR:   result = op_a | op_b;
         rv32alu_pkg::F3_AND:  result = op_a & op_b;
         default:              result = op_a & op_b;
      endcase
   end

   assign wr_done  = ok && rd != 5'd0 && {1'b0, rd} < 6'(rv32alu_pkg::REG_COUNT);
   assign pc_plus4 = pc_ff + 32'd4;

   always_comb begin
      wr.en   = s1_advance & wr_done;
      wr.idx  = rd;
      wr.data = result;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      pc_in = pc_ff;
      if (csr_valid) begin
         pc_in = {csr_wdata[31:2], 2'b00};
      end else if (s1_advance && ok) begin
         pc_in = pc_plus4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 32'd0;
         fwd_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         if (req_accept) begin
            fwd_ff <= wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_instr_ff <= req_instr_word;
      end
      if (s1_advance) begin
         out_dest_ff   <= ok ? rd : 5'd0;
         out_value_ff  <= ok ? result : 32'd0;
         out_done_ff   <= wr_done;
         out_pc_ff     <= ok ? pc_plus4 : pc_ff;
         out_status_ff <= ~ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_index  = out_dest_ff;
   assign rsp_write_value = out_value_ff;
   assign rsp_write_done  = out_done_ff;
   assign rsp_next_pc     = out_pc_ff;
   assign rsp_status      = out_status_ff;

endmodule
